// ===== rtl/core/ed3g_pkg.sv =====
// Shared types, constants and helpers for the 3x3 gray edge detector.
// No dependencies; used by scoped name in every rtl/core file except ed3g_ram.
`default_nettype none

package ed3g_pkg;

  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;
  localparam int GRAY_W    = 8;
  localparam int TDATA_W   = 32;
  localparam int IN_TDATA_W = 24;

  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 13;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_WIDTH      = 640;
  localparam int DEF_HEIGHT     = 480;
  localparam int DEF_THRESHOLD  = 150;
  localparam int MIN_DIM        = 3;

  // ceil(2^16 / 3): exact floor division by 3 for magnitudes below 2^15
  localparam int RECIP3   = 21846;
  localparam int WHITE    = 255;

  // result queue: one entry per pixel that produces results
  localparam int QDEPTH   = 8;
  localparam int QAW      = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } ed3g_reg_t;

  typedef logic [PIX_W-1:0] ed3g_pix_t;
  typedef logic [8:0][PIX_W-1:0] ed3g_win_t;

  // emit[0]: pixel (col-1,row-1); emit[1]: (col,row-1), right border;
  // emit[2]: (col,row), bottom border. inner: emit[0] is an inner pixel.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [2:0]       emit;
    logic             inner;
  } ed3g_meta_t;

  typedef struct packed {
    ed3g_meta_t        meta;
    logic [GRAY_W-1:0] gray;
  } ed3g_res_t;

  function automatic int clamp_dim(int v, int hi);
    int r;
    r = v;
    if (v < MIN_DIM) r = MIN_DIM;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ed3g_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ed3g_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ed3g_linebuf.sv =====
// Line stores (one RAM holding both older and previous rows) and the 3x3 window.
// Depends on ed3g_pkg and ed3g_ram.
`default_nettype none

module ed3g_linebuf #(
  parameter int MAX_WIDTH = ed3g_pkg::DEF_MAX_WIDTH,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire logic [CW-1:0]        col,
  input  wire ed3g_pkg::ed3g_pix_t  pix,
  input  wire ed3g_pkg::ed3g_meta_t meta,
  output logic                      s1_valid,
  output logic                      s2_valid,
  output ed3g_pkg::ed3g_win_t       win,
  output ed3g_pkg::ed3g_meta_t      s2_meta
);

  localparam int PW = ed3g_pkg::PIX_W;

  logic                 v1_r;
  logic [CW-1:0]        col1_r;
  ed3g_pkg::ed3g_pix_t  pix1_r;
  ed3g_pkg::ed3g_meta_t meta1_r;
  logic                 v2_r;
  ed3g_pkg::ed3g_meta_t meta2_r;
  ed3g_pkg::ed3g_win_t  win_r;
  ed3g_pkg::ed3g_win_t  win_nxt;
  logic [2*PW-1:0]      rd;
  ed3g_pkg::ed3g_pix_t  older;
  ed3g_pkg::ed3g_pix_t  prev;

  // Consecutive pixels always hit different columns (width >= 3), so the
  // write-back of one pixel never collides with the read of the next.
  ed3g_ram #(
    .WIDTH (2*PW),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (v1_r),
    .waddr (col1_r),
    .wdata ({prev, pix1_r}),
    .re    (acc),
    .raddr (col),
    .rdata (rd)
  );

  assign older = rd[2*PW-1:PW];
  assign prev  = rd[PW-1:0];

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[2] = older;
    win_nxt[5] = prev;
    win_nxt[8] = pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      win_r <= '0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      if (v1_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      col1_r  <= col;
      pix1_r  <= pix;
      meta1_r <= meta;
    end
    meta2_r <= meta1_r;
  end

  assign s1_valid = v1_r;
  assign s2_valid = v2_r;
  assign win      = win_r;
  assign s2_meta  = meta2_r;

endmodule

`default_nettype wire

// ===== rtl/core/ed3g_kernel.sv =====
// Kernel arithmetic: 16/-2 weighted sum over the window, divide by 3, threshold.
// Depends on ed3g_pkg.
`default_nettype none

module ed3g_kernel (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire ed3g_pkg::ed3g_win_t       win,
  input  wire ed3g_pkg::ed3g_meta_t      meta,
  input  wire logic [ed3g_pkg::CH_W-1:0] thr,
  output logic                           res_valid,
  output ed3g_pkg::ed3g_res_t            res
);

  localparam int GW = ed3g_pkg::GRAY_W;

  logic [8:0][9:0]      ct;
  logic [12:0]          nsum;
  logic [13:0]          c16;
  logic [13:0]          n2;
  logic signed [14:0]   diff;
  logic signed [14:0]   diff_r;
  logic                 v3_r;
  ed3g_pkg::ed3g_meta_t meta3_r;
  logic [29:0]          prod;
  logic [13:0]          q;
  logic [GW-1:0]        gray;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ct[k] = 10'(win[k][7:0]) + 10'(win[k][15:8]) + 10'(win[k][23:16]);
    end
    nsum = 13'(ct[0]) + 13'(ct[1]) + 13'(ct[2]) + 13'(ct[3])
         + 13'(ct[5]) + 13'(ct[6]) + 13'(ct[7]) + 13'(ct[8]);
    c16  = {ct[4], 4'b0};
    n2   = {nsum, 1'b0};
    diff = $signed({1'b0, c16}) - $signed({1'b0, n2});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    diff_r  <= diff;
    meta3_r <= meta;
  end

  // A negative sum gives a mean of zero or below, which maps to 0 either way,
  // so only the magnitude of a non-negative sum is divided.
  always_comb begin
    prod = 30'(diff_r[13:0]) * 30'(ed3g_pkg::RECIP3);
    q    = prod[29:16];
    if (!meta3_r.inner || diff_r[14]) begin
      gray = '0;
    end else if (q > {6'b0, thr}) begin
      gray = GW'(ed3g_pkg::WHITE);
    end else begin
      gray = q[GW-1:0];
    end
  end

  assign res_valid = v3_r;
  assign res.meta  = meta3_r;
  assign res.gray  = gray;

endmodule

`default_nettype wire

// ===== rtl/core/ed3g_outq.sv =====
// Result queue: one entry per pixel with results, unpacked into 1-3 output transactions.
// Depends on ed3g_pkg.
`default_nettype none

module ed3g_outq (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_valid,
  input  wire ed3g_pkg::ed3g_res_t               wr_res,
  output logic [ed3g_pkg::QAW:0]                 count,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ed3g_pkg::TDATA_W-1:0]           out_tdata,
  output logic                                   out_tlast
);

  localparam int QAW = ed3g_pkg::QAW;
  localparam int COL_W = ed3g_pkg::COL_W;
  localparam int ROW_W = ed3g_pkg::ROW_W;
  localparam int GW = ed3g_pkg::GRAY_W;

  ed3g_pkg::ed3g_res_t q_r [ed3g_pkg::QDEPTH];
  logic [QAW-1:0]      wptr_r;
  logic [QAW-1:0]      rptr_r;
  logic [QAW:0]        cnt_r;
  logic [2:0]          used_r;
  ed3g_pkg::ed3g_res_t head;
  logic [2:0]          rem;
  logic [2:0]          pick;
  logic                push;
  logic                pop;
  logic                xfer;
  logic [COL_W-1:0]    col_o;
  logic [ROW_W-1:0]    row_o;
  logic [GW-1:0]       gray_o;

  assign head = q_r[rptr_r];
  assign rem  = head.meta.emit & ~used_r;

  always_comb begin
    pick = 3'b000;
    if (rem[0]) pick = 3'b001;
    else if (rem[1]) pick = 3'b010;
    else if (rem[2]) pick = 3'b100;
  end

  always_comb begin
    col_o  = pick[0] ? head.meta.col - COL_W'(1) : head.meta.col;
    row_o  = (pick[0] || pick[1]) ? head.meta.row - ROW_W'(1) : head.meta.row;
    gray_o = pick[0] ? head.gray : '0;
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = ((rem & ~pick) == 3'b000);
  assign out_tdata  = {1'b0, gray_o, row_o, col_o};

  assign xfer = out_tvalid && out_tready;
  assign pop  = xfer && out_tlast;
  // drop pixels that produce no result
  assign push = wr_valid && (wr_res.meta.emit != 3'b000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QAW'(1);
      if (pop)  rptr_r <= rptr_r + QAW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QAW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QAW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
      if (pop) begin
        used_r <= '0;
      end else if (xfer) begin
        used_r <= used_r | pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= wr_res;
    end
  end

  assign count = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/edge_detect_3x3_gray_threshold.sv =====
// 3x3 Laplacian-style edge detector with gray output and threshold.
// Pixel path: stage-1 register, window register, kernel register, result queue.
// One pixel per cycle is accepted while in_tready is high; a pixel with two or three
// results takes one output transaction each, absorbed by an 8-entry result queue whose
// free space gates in_tready. Synchronous active-low reset clears counters, window,
// queue and sets width/height/threshold to 640/480/150; line store RAM is not cleared.
`default_nettype none

module edge_detect_3x3_gray_threshold #(
  parameter int MAX_WIDTH  = ed3g_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ed3g_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: red [7:0], green [15:8], blue [23:16]
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ed3g_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: out_column [10:0], out_row [22:11], gray [30:23], zero [31]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ed3g_pkg::TDATA_W-1:0]             out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [ed3g_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire logic [ed3g_pkg::CFG_DW-1:0]         cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int QAW = ed3g_pkg::QAW;
  localparam int COL_W = ed3g_pkg::COL_W;
  localparam int ROW_W = ed3g_pkg::ROW_W;
  localparam int RST_W = ed3g_pkg::clamp_dim(ed3g_pkg::DEF_WIDTH, MAX_WIDTH);
  localparam int RST_H = ed3g_pkg::clamp_dim(ed3g_pkg::DEF_HEIGHT, MAX_HEIGHT);

  logic [WW-1:0]        w_r;
  logic [HW-1:0]        h_r;
  logic [7:0]           thr_r;
  logic [CW-1:0]        col_r;
  logic [RW-1:0]        row_r;

  logic [11:0]          cfg_wv;
  logic [12:0]          cfg_hv;
  logic [WW+11:0]       wext;
  logic [HW+12:0]       hext;
  logic [WW-1:0]        w_cl;
  logic [HW-1:0]        h_cl;

  logic                 acc;
  logic [WW-1:0]        wm1;
  logic [HW-1:0]        hm1;
  logic                 col_wrap;
  logic [RW:0]          row_pre;
  logic [CW-1:0]        c0;
  logic [RW-1:0]        r0;
  logic [CW:0]          c_inc;
  logic [RW:0]          r_inc;
  logic [CW-1:0]        col_nxt;
  logic [RW-1:0]        row_nxt;
  logic [CW+COL_W-1:0]  cext;
  logic [RW+ROW_W-1:0]  rext;
  ed3g_pkg::ed3g_meta_t meta0;
  ed3g_pkg::ed3g_pix_t  pix0;

  logic                 s1_valid;
  logic                 s2_valid;
  ed3g_pkg::ed3g_win_t  win;
  ed3g_pkg::ed3g_meta_t s2_meta;
  logic                 res_valid;
  ed3g_pkg::ed3g_res_t  res;
  logic [QAW:0]         q_count;
  logic [QAW+1:0]       load;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_wv = cfg_wdata[11:0];
    cfg_hv = cfg_wdata[12:0];
    wext   = {{WW{1'b0}}, cfg_wv};
    hext   = {{HW{1'b0}}, cfg_hv};
    if (32'(cfg_wv) < ed3g_pkg::MIN_DIM) w_cl = WW'(ed3g_pkg::MIN_DIM);
    else if (32'(cfg_wv) > MAX_WIDTH)    w_cl = WW'(MAX_WIDTH);
    else                                 w_cl = wext[WW-1:0];
    if (32'(cfg_hv) < ed3g_pkg::MIN_DIM) h_cl = HW'(ed3g_pkg::MIN_DIM);
    else if (32'(cfg_hv) > MAX_HEIGHT)   h_cl = HW'(MAX_HEIGHT);
    else                                 h_cl = hext[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= WW'(RST_W);
      h_r   <= HW'(RST_H);
      thr_r <= 8'(ed3g_pkg::DEF_THRESHOLD);
    end else if (cfg_we) begin
      case (cfg_addr)
        ed3g_pkg::REG_IMAGE_WIDTH:  w_r   <= w_cl;
        ed3g_pkg::REG_IMAGE_HEIGHT: h_r   <= h_cl;
        ed3g_pkg::REG_THRESHOLD:    thr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- raster counters ----------------
  assign load      = (QAW+2)'(q_count) + (QAW+2)'(s1_valid) + (QAW+2)'(s2_valid)
                   + (QAW+2)'(res_valid);
  assign in_tready = (load < (QAW+2)'(ed3g_pkg::QDEPTH));
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    wm1      = w_r - WW'(1);
    hm1      = h_r - HW'(1);
    // restart row or frame if the dimensions shrank under the counters
    col_wrap = (col_r >= w_r);
    c0       = col_wrap ? '0 : col_r;
    row_pre  = col_wrap ? {1'b0, row_r} + (RW+1)'(1) : {1'b0, row_r};
    r0       = (row_pre >= h_r) ? '0 : row_pre[RW-1:0];

    c_inc = {1'b0, c0} + (CW+1)'(1);
    r_inc = {1'b0, r0} + (RW+1)'(1);
    if (c_inc >= w_r) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_r) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r0;
    end

    cext          = {{COL_W{1'b0}}, c0};
    rext          = {{ROW_W{1'b0}}, r0};
    meta0.col     = cext[COL_W-1:0];
    meta0.row     = rext[ROW_W-1:0];
    meta0.emit[0] = (r0 != '0) && (c0 != '0);
    meta0.emit[1] = (r0 != '0) && (c0 == wm1);
    meta0.emit[2] = (r0 == hm1);
    // pixel (c-1, r-1) is off the right and bottom borders by construction
    meta0.inner   = (c0 >= CW'(2)) && (r0 >= RW'(2));
    pix0          = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- datapath ----------------
  ed3g_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .col      (c0),
    .pix      (pix0),
    .meta     (meta0),
    .s1_valid (s1_valid),
    .s2_valid (s2_valid),
    .win      (win),
    .s2_meta  (s2_meta)
  );

  ed3g_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .win       (win),
    .meta      (s2_meta),
    .thr       (thr_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ed3g_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_valid   (res_valid),
    .wr_res     (res),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
